FILE: rtl/prot_pkg.sv
// shared types and constants for the point rotation block
package prot_pkg;

	localparam int COORD_WIDTH = 24;
	localparam int ANGLE_WIDTH = 32;
	localparam int OFF_WIDTH = COORD_WIDTH + 1;
	localparam int TRIG_WIDTH = 32;
	localparam int TRIG_FRAC = 28;
	localparam int PHASE_WIDTH = 32;
	localparam int SCALE_WIDTH = 31;
	localparam int PROD_WIDTH = 48;
	localparam int MAX_STAGES = 24;

	localparam logic signed [TRIG_WIDTH-1:0] CORDIC_GAIN_INV = 32'sd163008219;
	localparam logic signed [SCALE_WIDTH-1:0] RAD_TO_TURN = 31'sd683565276;
	localparam logic signed [SCALE_WIDTH-1:0] DEG_TO_TURN = 31'sd11930465;
	// rounding half of the dropped 16 bits plus one eighth turn above them
	localparam logic [PROD_WIDTH-1:0] PHASE_BIAS = 48'h2000_0000_8000;
	localparam logic signed [TRIG_WIDTH-1:0] EIGHTH_TURN = 32'sd536870912;

	localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
	localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

	localparam logic [31:0] ATAN_TURNS [MAX_STAGES] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] point_x;
		logic signed [COORD_WIDTH-1:0] point_y;
		logic signed [COORD_WIDTH-1:0] origin_x;
		logic signed [COORD_WIDTH-1:0] origin_y;
		logic signed [ANGLE_WIDTH-1:0] angle;
		logic angle_in_degrees;
	} job_t;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] rotated_x;
		logic signed [COORD_WIDTH-1:0] rotated_y;
		logic saturated;
	} result_t;

	typedef struct packed {
		logic signed [TRIG_WIDTH-1:0] x;
		logic signed [TRIG_WIDTH-1:0] y;
		logic signed [TRIG_WIDTH-1:0] z;
		logic [1:0] quad;
		logic signed [OFF_WIDTH-1:0] dx;
		logic signed [OFF_WIDTH-1:0] dy;
		logic signed [COORD_WIDTH-1:0] ox;
		logic signed [COORD_WIDTH-1:0] oy;
	} cordic_t;

endpackage

FILE: rtl/point_rotation_about_origin_top.sv
// point rotation about an origin: top level with the cordic cell chain
//
// channel  | signals              | handshake
// ---------+----------------------+-------------------------------------
// item in  | start, busy, job     | taken when start is high, busy low
// item out | done, result         | valid for the single cycle of done
//
// one item per clock; busy is never raised
// from start to done an item passes two front stages,
// one per cordic cell, and four for multiply and clamp
// reset clears only the valid chain; items in flight are dropped
// the receiver cannot stall, so each result shows for one cycle only
module point_rotation_about_origin_top #(
	parameter int ROTATION_STAGES = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  prot_pkg::job_t    job,
	output logic              done,
	output prot_pkg::result_t result
);

	localparam int LATENCY = ROTATION_STAGES + 6;

	prot_pkg::cordic_t chain [ROTATION_STAGES+1];
	logic chain_vld [ROTATION_STAGES+1];

	assign busy = 1'b0;

	prot_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.vld    (start),
		.job    (job),
		.vld_s2 (chain_vld[0]),
		.out_s2 (chain[0])
	);

	for (genvar i = 0; i < ROTATION_STAGES; i++) begin : g_cell
		prot_cell #(
			.STAGE (i)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.vld    (chain_vld[i]),
			.din    (chain[i]),
			.vld_s1 (chain_vld[i+1]),
			.out_s1 (chain[i+1])
		);
	end

	prot_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.vld       (chain_vld[ROTATION_STAGES]),
		.din       (chain[ROTATION_STAGES]),
		.vld_s4    (done),
		.result_s4 (result)
	);

	a_done_has_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LATENCY))
		else $error("result without a matching item");

	a_start_gives_done: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##LATENCY done)
		else $error("item lost in the pipeline");

	a_sat_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.saturated) |->
			(result.rotated_x == prot_pkg::COORD_MAX || result.rotated_x == prot_pkg::COORD_MIN ||
			 result.rotated_y == prot_pkg::COORD_MAX || result.rotated_y == prot_pkg::COORD_MIN))
		else $error("saturation flag without a clamped coordinate");

endmodule

FILE: rtl/prot_front.sv
// angle to phase conversion, quadrant split and offset from origin
module prot_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             vld,
	input  prot_pkg::job_t   job,
	output logic             vld_s2,
	output prot_pkg::cordic_t out_s2
);

	logic signed [prot_pkg::SCALE_WIDTH-1:0] scale;
	logic signed [prot_pkg::ANGLE_WIDTH+prot_pkg::SCALE_WIDTH-1:0] prod_full;
	logic [prot_pkg::PROD_WIDTH-1:0] prod_s1;
	logic [prot_pkg::PROD_WIDTH-1:0] biased;
	logic [prot_pkg::PHASE_WIDTH-1:0] phase;
	logic signed [prot_pkg::OFF_WIDTH-1:0] dx_s1;
	logic signed [prot_pkg::OFF_WIDTH-1:0] dy_s1;
	logic signed [prot_pkg::COORD_WIDTH-1:0] ox_s1;
	logic signed [prot_pkg::COORD_WIDTH-1:0] oy_s1;
	logic vld_s1;

	always_comb begin
		scale = job.angle_in_degrees ? prot_pkg::DEG_TO_TURN : prot_pkg::RAD_TO_TURN;
		prod_full = job.angle * scale;
		biased = prod_s1 + prot_pkg::PHASE_BIAS;
		phase = biased[prot_pkg::PROD_WIDTH-1:prot_pkg::PROD_WIDTH-prot_pkg::PHASE_WIDTH];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= prod_full[prot_pkg::PROD_WIDTH-1:0];
		dx_s1 <= prot_pkg::OFF_WIDTH'(job.point_x) - prot_pkg::OFF_WIDTH'(job.origin_x);
		dy_s1 <= prot_pkg::OFF_WIDTH'(job.point_y) - prot_pkg::OFF_WIDTH'(job.origin_y);
		ox_s1 <= job.origin_x;
		oy_s1 <= job.origin_y;

		out_s2.x <= prot_pkg::CORDIC_GAIN_INV;
		out_s2.y <= '0;
		out_s2.z <= $signed({2'b00, phase[prot_pkg::PHASE_WIDTH-3:0]}) - prot_pkg::EIGHTH_TURN;
		out_s2.quad <= phase[prot_pkg::PHASE_WIDTH-1:prot_pkg::PHASE_WIDTH-2];
		out_s2.dx <= dx_s1;
		out_s2.dy <= dy_s1;
		out_s2.ox <= ox_s1;
		out_s2.oy <= oy_s1;
	end

endmodule

FILE: rtl/prot_cell.sv
// one cordic rotation cell with its pipeline register
module prot_cell #(
	parameter int STAGE = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              vld,
	input  prot_pkg::cordic_t din,
	output logic              vld_s1,
	output prot_pkg::cordic_t out_s1
);

	localparam logic signed [prot_pkg::TRIG_WIDTH-1:0] ATAN =
		$signed(prot_pkg::ATAN_TURNS[STAGE]);

	logic signed [prot_pkg::TRIG_WIDTH-1:0] xs;
	logic signed [prot_pkg::TRIG_WIDTH-1:0] ys;
	prot_pkg::cordic_t nxt;

	always_comb begin
		xs = din.x >>> STAGE;
		ys = din.y >>> STAGE;
		nxt = din;
		if (!din.z[prot_pkg::TRIG_WIDTH-1]) begin
			nxt.x = din.x - ys;
			nxt.y = din.y + xs;
			nxt.z = din.z - ATAN;
		end else begin
			nxt.x = din.x + ys;
			nxt.y = din.y - xs;
			nxt.z = din.z + ATAN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= vld;
		end
	end

	always_ff @(posedge clk) begin
		out_s1 <= nxt;
	end

endmodule

FILE: rtl/prot_back.sv
// quadrant fold, offset rotation, rounding, origin add and clamp
module prot_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              vld,
	input  prot_pkg::cordic_t din,
	output logic              vld_s4,
	output prot_pkg::result_t result_s4
);

	localparam int MUL_W = prot_pkg::OFF_WIDTH + prot_pkg::TRIG_WIDTH;
	localparam int SUM_W = MUL_W + 1;
	localparam int RND_W = SUM_W - prot_pkg::TRIG_FRAC;
	localparam int ACC_W = RND_W + 1;
	localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1) << (prot_pkg::TRIG_FRAC - 1);

	logic signed [prot_pkg::TRIG_WIDTH-1:0] cos_v;
	logic signed [prot_pkg::TRIG_WIDTH-1:0] sin_v;
	logic signed [prot_pkg::TRIG_WIDTH-1:0] cos_s1;
	logic signed [prot_pkg::TRIG_WIDTH-1:0] sin_s1;
	logic signed [prot_pkg::OFF_WIDTH-1:0] dx_s1;
	logic signed [prot_pkg::OFF_WIDTH-1:0] dy_s1;
	logic signed [prot_pkg::COORD_WIDTH-1:0] ox_s1, ox_s2, ox_s3;
	logic signed [prot_pkg::COORD_WIDTH-1:0] oy_s1, oy_s2, oy_s3;
	logic signed [MUL_W-1:0] xc_s2, ys_s2, xs_s2, yc_s2;
	logic signed [SUM_W-1:0] sum_x, sum_y;
	logic signed [RND_W-1:0] rx_s3, ry_s3;
	logic signed [ACC_W-1:0] ax, ay;
	logic vld_s1, vld_s2, vld_s3;
	logic hi_x, lo_x, hi_y, lo_y;
	prot_pkg::result_t res;

	always_comb begin
		unique case (din.quad)
			2'd0: begin
				cos_v = din.x;
				sin_v = din.y;
			end
			2'd1: begin
				cos_v = -din.y;
				sin_v = din.x;
			end
			2'd2: begin
				cos_v = -din.x;
				sin_v = -din.y;
			end
			default: begin
				cos_v = din.y;
				sin_v = -din.x;
			end
		endcase
	end

	always_comb begin
		sum_x = SUM_W'(xc_s2) - SUM_W'(ys_s2) + HALF;
		sum_y = SUM_W'(xs_s2) + SUM_W'(yc_s2) + HALF;
		ax = ACC_W'(rx_s3) + ACC_W'(ox_s3);
		ay = ACC_W'(ry_s3) + ACC_W'(oy_s3);
		hi_x = ax > ACC_W'(prot_pkg::COORD_MAX);
		lo_x = ax < ACC_W'(prot_pkg::COORD_MIN);
		hi_y = ay > ACC_W'(prot_pkg::COORD_MAX);
		lo_y = ay < ACC_W'(prot_pkg::COORD_MIN);
		priority if (hi_x) begin
			res.rotated_x = prot_pkg::COORD_MAX;
		end else if (lo_x) begin
			res.rotated_x = prot_pkg::COORD_MIN;
		end else begin
			res.rotated_x = ax[prot_pkg::COORD_WIDTH-1:0];
		end
		priority if (hi_y) begin
			res.rotated_y = prot_pkg::COORD_MAX;
		end else if (lo_y) begin
			res.rotated_y = prot_pkg::COORD_MIN;
		end else begin
			res.rotated_y = ay[prot_pkg::COORD_WIDTH-1:0];
		end
		res.saturated = hi_x | lo_x | hi_y | lo_y;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		cos_s1 <= cos_v;
		sin_s1 <= sin_v;
		dx_s1 <= din.dx;
		dy_s1 <= din.dy;
		ox_s1 <= din.ox;
		oy_s1 <= din.oy;

		xc_s2 <= dx_s1 * cos_s1;
		ys_s2 <= dy_s1 * sin_s1;
		xs_s2 <= dx_s1 * sin_s1;
		yc_s2 <= dy_s1 * cos_s1;
		ox_s2 <= ox_s1;
		oy_s2 <= oy_s1;

		rx_s3 <= sum_x[SUM_W-1:prot_pkg::TRIG_FRAC];
		ry_s3 <= sum_y[SUM_W-1:prot_pkg::TRIG_FRAC];
		ox_s3 <= ox_s2;
		oy_s3 <= oy_s2;

		result_s4 <= res;
	end

endmodule
